// ===== rtl/lald_pkg.sv =====
// Package for the Lambertian area-light direct-illumination pipeline.
// Holds the fixed-point widths, the register indexes and the item and result types.
// Used by lambert_area_light_direct_top and lald_checker; depends on nothing.
`default_nettype none

package lald_pkg;

	// Field widths.
	localparam int COORD_WIDTH = 16;
	localparam int NORM_W      = 16;
	localparam int COLOR_W     = 16;
	localparam int AREA_W      = 24;
	localparam int RAD_W       = 32;

	// Difference vector and magnitude widths.
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int MAG_W   = 16;
	localparam int XTRA_W  = COORD_WIDTH - MAG_W;
	localparam int SHIFT_W = $clog2(XTRA_W + 1) + 1;

	// Geometry term widths.
	localparam int SQ_W    = 2 * MAG_W;
	localparam int S_W     = SQ_W + 2;
	localparam int SL_W    = 32;
	localparam int SH_W    = S_W - SL_W;
	localparam int VP_W    = MAG_W + 1 + NORM_W;
	localparam int DOT_W   = VP_W + 2;
	localparam int COS_W   = 32;
	localparam int P_W     = 2 * COS_W;
	localparam int DEN_W   = 2 * S_W;
	localparam int FRAC_SH = 20;
	localparam int NUM_W   = P_W + FRAC_SH;
	localparam int QB      = 50;
	localparam int REM_W   = DEN_W + 1;

	// Color scale widths: emit * surface * area * (2^32 / pi) / 2^32.
	localparam int INV_PI_W = 31;
	localparam logic [INV_PI_W-1:0] INV_PI = 31'd1367130551;
	localparam int EF_W   = 2 * COLOR_W;
	localparam int K_W    = EF_W + AREA_W;
	localparam int KL_W   = K_W / 2;
	localparam int KH_W   = K_W - KL_W;
	localparam int KP_W   = KH_W + INV_PI_W;
	localparam int KSUM_W = K_W + INV_PI_W;
	localparam int F_SH   = 32;
	localparam int F_W    = KSUM_W - F_SH;

	// Final product split.
	localparam int FL_W   = 28;
	localparam int FH_W   = F_W - FL_W;
	localparam int GL_W   = 25;
	localparam int GH_W   = QB - GL_W;
	localparam int PROD_W = F_W + QB;
	localparam int OUT_SH = 48;
	localparam int HI_W   = PROD_W - OUT_SH;

	// Clock edges from the accepting edge to the edge that takes the result.
	localparam int LATENCY = QB + 8;

	localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sd16384;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SURFACE_RED   = 3'd0,
		REG_SURFACE_GREEN = 3'd1,
		REG_SURFACE_BLUE  = 3'd2,
		REG_EMIT_RED      = 3'd3,
		REG_EMIT_GREEN    = 3'd4,
		REG_EMIT_BLUE     = 3'd5,
		REG_LIGHT_AREA    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] light_x;
		logic signed [COORD_WIDTH-1:0] light_y;
		logic signed [COORD_WIDTH-1:0] light_z;
		logic signed [COORD_WIDTH-1:0] hit_x;
		logic signed [COORD_WIDTH-1:0] hit_y;
		logic signed [COORD_WIDTH-1:0] hit_z;
		logic signed [NORM_W-1:0]      hit_normal_x;
		logic signed [NORM_W-1:0]      hit_normal_y;
		logic signed [NORM_W-1:0]      hit_normal_z;
		logic signed [NORM_W-1:0]      light_normal_x;
		logic signed [NORM_W-1:0]      light_normal_y;
		logic signed [NORM_W-1:0]      light_normal_z;
	} item_t;

	typedef struct packed {
		logic [RAD_W-1:0] radiance_red;
		logic [RAD_W-1:0] radiance_green;
		logic [RAD_W-1:0] radiance_blue;
		logic             degenerate;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/lambert_area_light_direct_top.sv =====
// Top level of the Lambertian area-light direct-illumination pipeline.
// Depends on lald_pkg for widths, register indexes and the item and result types.
// Each item passes the front stages, the divider and the output stages to the ports.
// Throughput: one item per cycle; busy stays low. The 50-stage divider sets the depth.
// Reset clears the configuration registers and all valid bits; the receiver cannot stall.
`default_nettype none

module lambert_area_light_direct_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  lald_pkg::item_t                    item,
	output logic                               done,
	output lald_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lald_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lald_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lald_pkg::*;

	function automatic logic signed [NORM_W-1:0] nsat(input logic signed [NORM_W-1:0] n);
		logic signed [NORM_W-1:0] r;
		r = n;
		if (n > NORM_MAX) begin
			r = NORM_MAX;
		end else if (n < -NORM_MAX) begin
			r = -NORM_MAX;
		end
		return r;
	endfunction

	// Configuration registers: a surface and an emit lane per color channel and one area.
	logic [COLOR_W-1:0] surface_q [3];
	logic [COLOR_W-1:0] emit_q [3];
	logic [AREA_W-1:0]  area_q;

	// Color scale, recomputed continuously from the configuration registers.
	logic [EF_W-1:0]   ef_q [3];
	logic [K_W-1:0]    k_q [3];
	logic [KP_W-1:0]   kh_q [3];
	logic [KP_W-1:0]   kl_q [3];
	logic [KSUM_W-1:0] fsum [3];
	logic [F_W-1:0]    f_q [3];

	// Item pipeline.
	logic                            accept;
	logic                            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [DIFF_W-1:0]        v_s1 [3];
	logic signed [NORM_W-1:0]        nh_s1 [3];
	logic signed [NORM_W-1:0]        nl_s1 [3];
	logic                            neg [3];
	logic [COORD_WIDTH-1:0]          magf [3];
	logic [COORD_WIDTH-1:0]          vor;
	logic [SHIFT_W-1:0]              shamt;
	logic [MAG_W-1:0]                mag [3];
	logic [MAG_W-1:0]                mag_s2 [3];
	logic signed [MAG_W:0]           vs_s2 [3];
	logic signed [NORM_W-1:0]        nh_s2 [3];
	logic signed [NORM_W-1:0]        nl_s2 [3];
	logic                            degen_s2, degen_s3, degen_s4, degen_s5;
	logic [SQ_W-1:0]                 sq_s3 [3];
	logic signed [VP_W-1:0]          ph_s3 [3];
	logic signed [VP_W-1:0]          pl_s3 [3];
	logic signed [DOT_W-1:0]         dh, dl;
	logic [S_W-1:0]                  s_s4;
	logic [COS_W-1:0]                ch_s4, cl_s4;
	logic [P_W-1:0]                  p_s5;
	logic [2*SL_W-1:0]               sll_s5;
	logic [SL_W+SH_W-1:0]            slh_s5;
	logic [2*SH_W-1:0]               shh_s5;
	logic [DEN_W-1:0]                den;
	logic [NUM_W-1:0]                num;

	// Divider stages: entry k holds stage 6 + k.
	logic [REM_W-1:0] rem_s6 [QB+1];
	logic [QB-1:0]    nq_s6 [QB+1];
	logic [DEN_W-1:0] den_s6 [QB+1];
	logic             degen_s6 [QB+1];
	logic             vld_s6 [QB+1];

	// Scaling and output stages.
	logic                   vld_s57, vld_s58;
	logic                   degen_s57;
	logic [FL_W+GL_W-1:0]   ppll_s57 [3];
	logic [FL_W+GH_W-1:0]   pplh_s57 [3];
	logic [FH_W+GL_W-1:0]   pphl_s57 [3];
	logic [FH_W+GH_W-1:0]   pphh_s57 [3];
	logic [PROD_W-1:0]      psum [3];
	logic [RAD_W-1:0]       rad [3];
	result_t                res_s58;

	// The block never holds off either channel.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				surface_q[c] <= '0;
				emit_q[c]    <= '0;
			end
			area_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SURFACE_RED:   surface_q[0] <= cfg_data[COLOR_W-1:0];
				REG_SURFACE_GREEN: surface_q[1] <= cfg_data[COLOR_W-1:0];
				REG_SURFACE_BLUE:  surface_q[2] <= cfg_data[COLOR_W-1:0];
				REG_EMIT_RED:      emit_q[0]    <= cfg_data[COLOR_W-1:0];
				REG_EMIT_GREEN:    emit_q[1]    <= cfg_data[COLOR_W-1:0];
				REG_EMIT_BLUE:     emit_q[2]    <= cfg_data[COLOR_W-1:0];
				REG_LIGHT_AREA:    area_q       <= cfg_data[AREA_W-1:0];
				default: ;
			endcase
		end
	end

	// The color scale f = emit * surface * area * (2^32 / pi) / 2^32 settles through ef, k,
	// kh, kl and f after a write, well before a later item reaches the last stages.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fsum[c] = (KSUM_W'(kh_q[c]) << KL_W) + KSUM_W'(kl_q[c]);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ef_q[c] <= emit_q[c] * surface_q[c];
			k_q[c]  <= ef_q[c] * area_q;
			kh_q[c] <= k_q[c][K_W-1:KL_W] * INV_PI;
			kl_q[c] <= k_q[c][KL_W-1:0] * INV_PI;
			f_q[c]  <= fsum[c][KSUM_W-1:F_SH];
		end
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: difference vector and saturated normals.
	always_ff @(posedge clk) begin
		v_s1[0]  <= DIFF_W'(item.light_x) - DIFF_W'(item.hit_x);
		v_s1[1]  <= DIFF_W'(item.light_y) - DIFF_W'(item.hit_y);
		v_s1[2]  <= DIFF_W'(item.light_z) - DIFF_W'(item.hit_z);
		nh_s1[0] <= nsat(item.hit_normal_x);
		nh_s1[1] <= nsat(item.hit_normal_y);
		nh_s1[2] <= nsat(item.hit_normal_z);
		nl_s1[0] <= nsat(item.light_normal_x);
		nl_s1[1] <= nsat(item.light_normal_y);
		nl_s1[2] <= nsat(item.light_normal_z);
	end

	// Stage 2 logic: magnitudes, the coincident-point test and the common right shift
	// that brings wide magnitudes back under 16 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i]  = v_s1[i][DIFF_W-1];
			magf[i] = neg[i] ? COORD_WIDTH'(-v_s1[i]) : COORD_WIDTH'(v_s1[i]);
		end
		vor   = magf[0] | magf[1] | magf[2];
		shamt = '0;
		for (int k = 0; k < XTRA_W; k++) begin
			if (vor[MAG_W+k]) begin
				shamt = SHIFT_W'(k + 1);
			end
		end
		for (int i = 0; i < 3; i++) begin
			mag[i] = MAG_W'(magf[i] >> shamt);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= mag[i];
			vs_s2[i]  <= neg[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
			nh_s2[i]  <= nh_s1[i];
			nl_s2[i]  <= nl_s1[i];
		end
		degen_s2 <= (vor == '0);
	end

	// Stage 3: squares and the dot-product terms.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= mag_s2[i] * mag_s2[i];
			ph_s3[i] <= vs_s2[i] * nh_s2[i];
			pl_s3[i] <= vs_s2[i] * nl_s2[i];
		end
		degen_s3 <= degen_s2;
	end

	// Stage 4: squared distance and the two cosines clamped at zero.
	always_comb begin
		dh = DOT_W'(ph_s3[0]) + DOT_W'(ph_s3[1]) + DOT_W'(ph_s3[2]);
		dl = -(DOT_W'(pl_s3[0]) + DOT_W'(pl_s3[1]) + DOT_W'(pl_s3[2]));
	end

	always_ff @(posedge clk) begin
		s_s4     <= S_W'(sq_s3[0]) + S_W'(sq_s3[1]) + S_W'(sq_s3[2]);
		ch_s4    <= (!dh[DOT_W-1] && dh != '0) ? dh[COS_W-1:0] : '0;
		cl_s4    <= (!dl[DOT_W-1] && dl != '0) ? dl[COS_W-1:0] : '0;
		degen_s4 <= degen_s3;
	end

	// Stage 5: cosine product and the partial products of the squared distance squared.
	always_ff @(posedge clk) begin
		p_s5     <= ch_s4 * cl_s4;
		sll_s5   <= s_s4[SL_W-1:0] * s_s4[SL_W-1:0];
		slh_s5   <= s_s4[SL_W-1:0] * s_s4[S_W-1:SL_W];
		shh_s5   <= s_s4[S_W-1:SL_W] * s_s4[S_W-1:SL_W];
		degen_s5 <= degen_s4;
	end

	// Stage 6: divisor s^2 and dividend p * 2^20. The quotient stays below 2^50,
	// so the top bits of the dividend already lie below the divisor.
	always_comb begin
		den = DEN_W'(sll_s5) + (DEN_W'(slh_s5) << (SL_W + 1))
			+ (DEN_W'(shh_s5) << (2 * SL_W));
		num = {p_s5, {FRAC_SH{1'b0}}};
	end

	always_ff @(posedge clk) begin
		rem_s6[0]   <= REM_W'(num[NUM_W-1:QB]);
		nq_s6[0]    <= num[QB-1:0];
		den_s6[0]   <= den;
		degen_s6[0] <= degen_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6[0] <= 1'b0;
		end else begin
			vld_s6[0] <= vld_s5;
		end
	end

	// Restoring divider, one quotient bit per stage. The dividend bits shift out of
	// the top of nq while quotient bits shift into its bottom.
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [REM_W-1:0] trial;
		logic             fits;

		assign trial = {rem_s6[k][REM_W-2:0], nq_s6[k][QB-1]};
		assign fits  = (trial >= {1'b0, den_s6[k]});

		always_ff @(posedge clk) begin
			rem_s6[k+1]   <= fits ? (trial - {1'b0, den_s6[k]}) : trial;
			nq_s6[k+1]    <= {nq_s6[k][QB-2:0], fits};
			den_s6[k+1]   <= den_s6[k];
			degen_s6[k+1] <= degen_s6[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[k+1] <= 1'b0;
			end else begin
				vld_s6[k+1] <= vld_s6[k];
			end
		end
	end

	// Stage 57: partial products of f * g for each channel.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ppll_s57[c] <= f_q[c][FL_W-1:0] * nq_s6[QB][GL_W-1:0];
			pplh_s57[c] <= f_q[c][FL_W-1:0] * nq_s6[QB][QB-1:GL_W];
			pphl_s57[c] <= f_q[c][F_W-1:FL_W] * nq_s6[QB][GL_W-1:0];
			pphh_s57[c] <= f_q[c][F_W-1:FL_W] * nq_s6[QB][QB-1:GL_W];
		end
		degen_s57 <= degen_s6[QB];
	end

	// Stage 58 logic: sum, drop 48 fraction bits and saturate.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			psum[c] = PROD_W'(ppll_s57[c])
				+ (PROD_W'(pplh_s57[c]) << GL_W)
				+ (PROD_W'(pphl_s57[c]) << FL_W)
				+ (PROD_W'(pphh_s57[c]) << (FL_W + GL_W));
			if (|psum[c][PROD_W-1:OUT_SH+RAD_W]) begin
				rad[c] = '1;
			end else begin
				rad[c] = psum[c][OUT_SH+RAD_W-1:OUT_SH];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s58.radiance_red   <= degen_s57 ? '0 : rad[0];
		res_s58.radiance_green <= degen_s57 ? '0 : rad[1];
		res_s58.radiance_blue  <= degen_s57 ? '0 : rad[2];
		res_s58.degenerate     <= degen_s57;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s57 <= 1'b0;
			vld_s58 <= 1'b0;
		end else begin
			vld_s57 <= vld_s6[QB];
			vld_s58 <= vld_s57;
		end
	end

	assign done   = vld_s58;
	assign result = res_s58;

endmodule

`default_nettype wire

// ===== rtl/lald_checker.sv =====
// Port-level checker for lambert_area_light_direct_top and its bind statement.
// Depends on lald_pkg for the item and result types and the pipeline latency.
`default_nettype none

module lald_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input lald_pkg::item_t   item,
	input logic              done,
	input lald_pkg::result_t result
);
	import lald_pkg::*;

	logic accept;
	logic coincide;

	assign accept   = start && !busy;
	assign coincide = accept && (item.light_x == item.hit_x)
		&& (item.light_y == item.hit_y) && (item.light_z == item.hit_z);

	// Every result traces back to an accepted item.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching input transaction");

	// Coincident points give a degenerate result.
	a_degen_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(coincide, LATENCY)) |-> result.degenerate)
		else $error("coincident points did not flag degenerate");

	// Only coincident points give a degenerate result.
	a_degen_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> $past(coincide, LATENCY))
		else $error("degenerate flagged for separate points");

	// A degenerate result carries zero radiance.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.radiance_red == '0
		&& result.radiance_green == '0 && result.radiance_blue == '0))
		else $error("degenerate result with nonzero radiance");

endmodule

bind lambert_area_light_direct_top lald_checker u_lald_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for lambert_area_light_direct_top, the direct area-light shading block.
// It predicts each result from the item and the register settings and checks it field by field.
// Depends on lald_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
	import lald_pkg::*;

	localparam longint unsigned RECIP_PI = 64'd1367130551;
	localparam int LAT_WAIT = 70;
	localparam int STALL_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Register copy used for prediction.
	logic [15:0] refl_r, refl_g, refl_b, glow_r, glow_g, glow_b;
	logic [23:0] lamp_area;

	result_t pending_light[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int degenerate_seen = 0;
	int saturated_seen = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;

	lambert_area_light_direct_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Normal components are saturated to the unit range first.
	function automatic longint clamp_normal(logic signed [15:0] n);
		longint x;
		x = longint'(n);
		if (x > 16384) x = 16384;
		if (x < -16384) x = -16384;
		return x;
	endfunction

	// One color channel: emit * surface * area / pi times the geometry term, saturated.
	function automatic logic [31:0] channel_light(logic [15:0] glow, logic [15:0] refl,
			logic [127:0] geom);
		logic [127:0] k, f, prod;
		k = 128'(glow) * 128'(refl) * 128'(lamp_area);
		f = (k * 128'(RECIP_PI)) >> 32;
		prod = (f * geom) >> 48;
		if (prod > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
		return prod[31:0];
	endfunction

	function automatic result_t predict_light(item_t it);
		longint d[3];
		longint nh[3];
		longint nl[3];
		longint dot_h, dot_l;
		logic [127:0] sq, num, geom;
		result_t r;
		d[0] = longint'(it.light_x) - longint'(it.hit_x);
		d[1] = longint'(it.light_y) - longint'(it.hit_y);
		d[2] = longint'(it.light_z) - longint'(it.hit_z);
		nh[0] = clamp_normal(it.hit_normal_x);
		nh[1] = clamp_normal(it.hit_normal_y);
		nh[2] = clamp_normal(it.hit_normal_z);
		nl[0] = clamp_normal(it.light_normal_x);
		nl[1] = clamp_normal(it.light_normal_y);
		nl[2] = clamp_normal(it.light_normal_z);
		r = '0;
		if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		sq = 0;
		dot_h = 0;
		dot_l = 0;
		for (int i = 0; i < 3; i++) begin
			sq += 128'(d[i] * d[i]);
			dot_h += d[i] * nh[i];
			dot_l -= d[i] * nl[i];
		end
		if (dot_h < 0) dot_h = 0;
		if (dot_l < 0) dot_l = 0;
		num = (128'(dot_h) * 128'(dot_l)) << 20;
		geom = (num / sq) / sq;
		geom = {64'd0, geom[63:0]};
		r.radiance_red = channel_light(glow_r, refl_r, geom);
		r.radiance_green = channel_light(glow_g, refl_g, geom);
		r.radiance_blue = channel_light(glow_b, refl_b, geom);
		return r;
	endfunction

	// Track accepted transactions on all three channels and check each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refl_r <= '0; refl_g <= '0; refl_b <= '0;
			glow_r <= '0; glow_g <= '0; glow_b <= '0;
			lamp_area <= '0;
		end else begin
			logic moved;
			moved = (cfg_valid && cfg_ready) || done || (start && !busy);
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SURFACE_RED: refl_r <= cfg_data[15:0];
					REG_SURFACE_GREEN: refl_g <= cfg_data[15:0];
					REG_SURFACE_BLUE: refl_b <= cfg_data[15:0];
					REG_EMIT_RED: glow_r <= cfg_data[15:0];
					REG_EMIT_GREEN: glow_g <= cfg_data[15:0];
					REG_EMIT_BLUE: glow_b <= cfg_data[15:0];
					REG_LIGHT_AREA: lamp_area <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				result_t want;
				results_seen++;
				if (pending_light.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					errors++;
				end else begin
					want = pending_light.pop_front();
					if (want.degenerate) degenerate_seen++;
					if (want.radiance_red == 32'hFFFF_FFFF) saturated_seen++;
					if (result.radiance_red !== want.radiance_red) begin
						$display("%0t: radiance_red expected %h actual %h", $time,
							want.radiance_red, result.radiance_red);
						errors++;
					end
					if (result.radiance_green !== want.radiance_green) begin
						$display("%0t: radiance_green expected %h actual %h", $time,
							want.radiance_green, result.radiance_green);
						errors++;
					end
					if (result.radiance_blue !== want.radiance_blue) begin
						$display("%0t: radiance_blue expected %h actual %h", $time,
							want.radiance_blue, result.radiance_blue);
						errors++;
					end
					if (result.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, result.degenerate);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				pending_light.push_back(predict_light(item));
			end
		end
	end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress, %0d results outstanding", $time, pending_light.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Send one item; start stays high until a gap or a pause lowers it.
	task automatic send_item(item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	// Stop sending and let every expected result arrive.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_light.size() != 0) @(posedge clk);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	// One register write; valid drops for a cycle before the next write.
	task automatic write_reg(cfg_reg_t idx, logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_colors(logic [15:0] refl, logic [15:0] glow, logic [23:0] area);
		write_reg(REG_SURFACE_RED, 24'(refl));
		write_reg(REG_SURFACE_GREEN, 24'(refl ^ 16'h5A5A));
		write_reg(REG_SURFACE_BLUE, 24'(~refl));
		write_reg(REG_EMIT_RED, 24'(glow));
		write_reg(REG_EMIT_GREEN, 24'(glow >> 1));
		write_reg(REG_EMIT_BLUE, 24'(glow ^ 16'hA5A5));
		write_reg(REG_LIGHT_AREA, area);
	endtask

	function automatic item_t make_item(logic [15:0] lx, ly, lz, hx, hy, hz,
			logic [15:0] nhx, nhy, nhz, nlx, nly, nlz);
		item_t it;
		it.light_x = lx; it.light_y = ly; it.light_z = lz;
		it.hit_x = hx; it.hit_y = hy; it.hit_z = hz;
		it.hit_normal_x = nhx; it.hit_normal_y = nhy; it.hit_normal_z = nhz;
		it.light_normal_x = nlx; it.light_normal_y = nly; it.light_normal_z = nlz;
		return it;
	endfunction

	// A sample with facing normals and a light offset of random reach.
	function automatic item_t facing_item();
		item_t it;
		int reach;
		logic signed [15:0] c[3];
		int sgn;
		reach = 1 << $urandom_range(0, 15);
		it = make_item($urandom, $urandom, $urandom, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		c[0] = $urandom_range(0, reach) - reach / 2;
		c[1] = $urandom_range(0, reach) - reach / 2;
		c[2] = $urandom_range(0, reach) - reach / 2;
		it.hit_x = it.light_x - c[0];
		it.hit_y = it.light_y - c[1];
		it.hit_z = it.light_z - c[2];
		sgn = (c[0] < 0) ? -1 : 1;
		it.hit_normal_x = sgn * int'($urandom_range(0, 16384));
		it.light_normal_x = -sgn * int'($urandom_range(0, 16384));
		sgn = (c[1] < 0) ? -1 : 1;
		it.hit_normal_y = sgn * int'($urandom_range(0, 16384));
		it.light_normal_y = -sgn * int'($urandom_range(0, 16384));
		sgn = (c[2] < 0) ? -1 : 1;
		it.hit_normal_z = sgn * int'($urandom_range(0, 16384));
		it.light_normal_z = -sgn * int'($urandom_range(0, 16384));
		return it;
	endfunction

	// After reset all registers are zero, so every result must be zero.
	task automatic test_reset_values();
		send_item(make_item(16'h0100, 0, 0, 0, 0, 0, 16384, 0, 0, -16384, 0, 0));
		send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 16384));
		drain();
	endtask

	// Extremes of the fields and the special cases.
	task automatic test_directed();
		write_colors(16'h8000, 16'h0100, 24'h000100);
		// Light straight above the hit point, normals facing.
		send_item(make_item(0, 0, 16'h0100, 0, 0, 0, 0, 0, 16384, 0, 0, -16384));
		// Coincident points, at zero and at the extremes.
		send_item(make_item(0, 0, 0, 0, 0, 0, 16384, 0, 0, 16384, 0, 0));
		send_item(make_item(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
			0, 16384, 0, 0, -16384, 0));
		// Back-facing surface and back-facing light.
		send_item(make_item(0, 0, 16'h0100, 0, 0, 0, 0, 0, -16384, 0, 0, -16384));
		send_item(make_item(0, 0, 16'h0100, 0, 0, 0, 0, 0, 16384, 0, 0, 16384));
		// Largest separation: along x, along y with the opposite sign, and along all axes.
		send_item(make_item(16'h7FFF, 0, 0, 16'h8000, 0, 0, 16384, 0, 0, -16384, 0, 0));
		send_item(make_item(0, 16'h8000, 0, 0, 16'h7FFF, 0, 0, -16384, 0, 0, 16384, 0));
		send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			9459, 9459, 9459, -9459, -9459, -9459));
		// Smallest separation: saturates the blue channel.
		send_item(make_item(0, 0, 16'h0001, 0, 0, 0, 0, 0, 16384, 0, 0, -16384));
		// Normals outside the unit range are saturated.
		send_item(make_item(0, 0, 16'h0200, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h8000));
		send_item(make_item(0, 0, 16'h0200, 0, 0, 0, 16'hFFFF, 16'h4001, 16'hBFFF,
			16'h0001, 16'hC000, 16'h8001));
		drain();
		// Registers at their extremes.
		write_colors(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_item(make_item(0, 0, 16'h7FFF, 0, 0, 16'h8000, 0, 0, 16384, 0, 0, -16384));
		send_item(make_item(0, 16'h0100, 0, 0, 0, 0, 0, 16384, 0, 0, -16384, 0));
		drain();
		write_colors(16'h0000, 16'h0001, 24'h000001);
		send_item(make_item(0, 16'h0010, 0, 0, 0, 0, 0, 16384, 0, 0, -16384, 0));
		drain();
	endtask

	// A write to the unused index must leave every register alone.
	task automatic test_unused_index();
		write_colors(16'h4000, 16'h0200, 24'h000400);
		cfg_valid <= 1'b1;
		cfg_index <= 3'd7;
		cfg_data <= 24'hFFFFFF;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		send_item(make_item(0, 16'h0300, 0, 0, 0, 0, 0, 16384, 0, 0, -16384, 0));
		drain();
	endtask

	// Random phases under several settings; gaps stop in the last phase.
	task automatic test_random();
		item_t it;
		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 8) gaps_on = 1'b0;
			write_colors($urandom, $urandom, $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
			for (int n = 0; n < 200; n++) begin
				case ($urandom_range(0, 9))
					0: it = make_item($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
					1: begin
						it = facing_item();
						it.hit_x = it.light_x;
						it.hit_y = it.light_y;
						it.hit_z = it.light_z;
					end
					2: begin
						it = facing_item();
						it.hit_normal_x = -it.hit_normal_x;
						it.hit_normal_y = -it.hit_normal_y;
						it.hit_normal_z = -it.hit_normal_z;
					end
					default: it = facing_item();
				endcase
				send_item(it);
			end
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_unused_index();
		test_random();
		$display("Sent %0d items, checked %0d results: %0d coincident, %0d saturated red.",
			items_sent, results_seen, degenerate_seen, saturated_seen);
		$display("Covered reset values, register extremes, back-facing and clamped normals.");
		if (errors == 0 && pending_light.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
